// ===== rtl/bfas_pkg.sv =====
// Shared types and constants for the brute-force assignment solver.
package bfas_pkg;

  localparam int COST_W       = 16;
  localparam int BOUND_W      = 19;
  localparam int SIZE_W       = 4;
  localparam int PIDX_W       = 3;
  localparam int MAX_SIZE_DEF = 8;
  localparam int MAX_SIZE_LIM = 10;
  localparam int QADDR_W      = $clog2(MAX_SIZE_LIM * MAX_SIZE_LIM);
  localparam int QUEUE_DEPTH  = 2;
  localparam int CFG_IDX_W    = 1;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 4'd4;
  localparam logic [BOUND_W-1:0] BOUND_RESET = 19'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROBLEM_SIZE = 1'b0,
    CFG_COST_BOUND   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [COST_W-1:0] cost_value;
    logic              last_entry;
  } in_req_t;

  typedef struct packed {
    logic [PIDX_W-1:0]  person_index;
    logic [PIDX_W-1:0]  assigned_job;
    logic [BOUND_W-1:0] total_cost;
    logic               found;
    logic               last_result;
  } out_res_t;

  typedef struct packed {
    logic [COST_W-1:0]  cost_value;
    logic               last_entry;
    logic               store;
    logic [QADDR_W-1:0] addr;
  } load_req_t;

endpackage

// ===== rtl/bfas_front.sv =====
// Front end: accepts matrix entries, classifies them and assigns load addresses.
module bfas_front #(
  parameter int MAX_SIZE = bfas_pkg::MAX_SIZE_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  bfas_pkg::in_req_t                       in_data,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE+1)-1:0]  nn,
  input  logic                                    q_full,
  output logic                                    q_push,
  output bfas_pkg::load_req_t                     q_req
);

  localparam int LOAD_W = $clog2(MAX_SIZE * MAX_SIZE + 1);

  logic [LOAD_W-1:0] load_cnt_r, load_cnt_nxt;
  logic              accept;
  logic              store;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign store    = load_cnt_r < nn;
  assign q_push   = accept;

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    if (accept) begin
      if (in_data.last_entry) begin
        load_cnt_nxt = '0;
      end else if (store) begin
        load_cnt_nxt = load_cnt_r + LOAD_W'(1);
      end
    end
  end

  always_comb begin
    q_req.cost_value = in_data.cost_value;
    q_req.last_entry = in_data.last_entry;
    q_req.store      = store;
    q_req.addr       = bfas_pkg::QADDR_W'(load_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
    end
  end

endmodule

// ===== rtl/bfas_queue.sv =====
// Short request queue between the front end and the search engine.
module bfas_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bfas_pkg::load_req_t push_req,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output bfas_pkg::load_req_t head_req
);

  localparam int DEPTH = bfas_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bfas_pkg::load_req_t entry_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                do_push;
  logic                do_pop;

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_req   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/bfas_back.sv =====
// Search engine: cost matrix store, permutation walk, best tracking and result register.
module bfas_back #(
  parameter int MAX_SIZE = bfas_pkg::MAX_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  bfas_pkg::load_req_t              q_head,
  output logic                             q_pop,
  input  logic [$clog2(MAX_SIZE+1)-1:0]    n,
  input  logic [bfas_pkg::BOUND_W-1:0]     cost_bound,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bfas_pkg::out_res_t               out_data
);

  localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int CNT_W  = $clog2(MAX_SIZE + 1);
  localparam int ADDR_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;
  localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int SUM_W  = bfas_pkg::COST_W + $clog2(MAX_SIZE);
  localparam int CMP_W  = (SUM_W > bfas_pkg::BOUND_W) ? SUM_W : bfas_pkg::BOUND_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DESC = 6'b000010,
    ST_EVAL = 6'b000100,
    ST_UNDO = 6'b001000,
    ST_NEXT = 6'b010000,
    ST_EMIT = 6'b100000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [bfas_pkg::COST_W-1:0]  mem_r [DEPTH];
  logic [bfas_pkg::COST_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0]            rd_addr;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;

  logic [IDX_W-1:0]             lvl_r, lvl_nxt;
  logic [CNT_W-1:0]             cnt_r [MAX_SIZE];
  logic [CNT_W-1:0]             cnt_nxt [MAX_SIZE];
  logic [IDX_W-1:0]             order_r [MAX_SIZE];
  logic [IDX_W-1:0]             order_nxt [MAX_SIZE];
  logic [IDX_W-1:0]             best_order_r [MAX_SIZE];
  logic [IDX_W-1:0]             best_order_nxt [MAX_SIZE];
  logic [bfas_pkg::BOUND_W-1:0] best_r, best_nxt;
  logic                         found_r, found_nxt;

  logic [IDX_W-1:0]             ev_idx_r, ev_idx_nxt;
  logic [ADDR_W-1:0]            ev_row_r, ev_row_nxt;
  logic                         ev_issue_r, ev_issue_nxt;
  logic                         rd_valid_r, rd_valid_nxt;
  logic                         rd_last_r, rd_last_nxt;
  logic [SUM_W-1:0]             acc_r, acc_nxt;
  logic [IDX_W-1:0]             emit_k_r, emit_k_nxt;

  logic                         out_valid_r, out_valid_nxt;
  bfas_pkg::out_res_t           out_data_r, out_data_nxt;

  logic [SUM_W-1:0]             sum;
  logic                         ev_last;
  logic                         leaf;
  logic [CNT_W-1:0]             c_cur;
  logic [IDX_W-1:0]             c_idx;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mem_waddr = q_head.addr[ADDR_W-1:0];
  assign rd_addr   = ev_row_r + ADDR_W'(order_r[ev_idx_r]);
  assign sum       = acc_r + SUM_W'(rd_data_r);
  assign ev_last   = (CNT_W'(ev_idx_r) + CNT_W'(1)) == n;
  assign leaf      = (CNT_W'(lvl_r) + CNT_W'(1)) >= n;
  assign c_cur     = cnt_r[lvl_r];
  assign c_idx     = IDX_W'(c_cur);

  always_comb begin
    state_nxt      = state_r;
    lvl_nxt        = lvl_r;
    cnt_nxt        = cnt_r;
    order_nxt      = order_r;
    best_order_nxt = best_order_r;
    best_nxt       = best_r;
    found_nxt      = found_r;
    ev_idx_nxt     = ev_idx_r;
    ev_row_nxt     = ev_row_r;
    ev_issue_nxt   = ev_issue_r;
    rd_valid_nxt   = 1'b0;
    rd_last_nxt    = 1'b0;
    acc_nxt        = acc_r;
    emit_k_nxt     = emit_k_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          mem_we = q_head.store;
          if (q_head.last_entry) begin
            best_nxt  = cost_bound;
            found_nxt = 1'b0;
            lvl_nxt   = '0;
            for (int e = 0; e < MAX_SIZE; e++) begin
              order_nxt[e] = IDX_W'(e);
            end
            state_nxt = ST_DESC;
          end
        end
      end

      ST_DESC: begin
        if (leaf) begin
          ev_idx_nxt   = '0;
          ev_row_nxt   = '0;
          ev_issue_nxt = 1'b1;
          acc_nxt      = '0;
          state_nxt    = ST_EVAL;
        end else begin
          cnt_nxt[lvl_r] = CNT_W'(lvl_r);
          lvl_nxt        = lvl_r + IDX_W'(1);
        end
      end

      ST_EVAL: begin
        if (ev_issue_r) begin
          rd_valid_nxt = 1'b1;
          rd_last_nxt  = ev_last;
          if (ev_last) begin
            ev_issue_nxt = 1'b0;
          end else begin
            ev_idx_nxt = ev_idx_r + IDX_W'(1);
            ev_row_nxt = ev_row_r + ADDR_W'(n);
          end
        end
        if (rd_valid_r) begin
          acc_nxt = sum;
          if (rd_last_r) begin
            if (CMP_W'(sum) < CMP_W'(best_r)) begin
              best_nxt       = bfas_pkg::BOUND_W'(sum);
              found_nxt      = 1'b1;
              best_order_nxt = order_r;
            end
            if (lvl_r == '0) begin
              emit_k_nxt = '0;
              state_nxt  = ST_EMIT;
            end else begin
              lvl_nxt   = lvl_r - IDX_W'(1);
              state_nxt = ST_UNDO;
            end
          end
        end
      end

      ST_UNDO: begin
        order_nxt[lvl_r] = order_r[c_idx];
        order_nxt[c_idx] = order_r[lvl_r];
        cnt_nxt[lvl_r]   = c_cur + CNT_W'(1);
        state_nxt        = ST_NEXT;
      end

      ST_NEXT: begin
        if (c_cur < n) begin
          order_nxt[lvl_r] = order_r[c_idx];
          order_nxt[c_idx] = order_r[lvl_r];
          lvl_nxt          = lvl_r + IDX_W'(1);
          state_nxt        = ST_DESC;
        end else if (lvl_r == '0) begin
          emit_k_nxt = '0;
          state_nxt  = ST_EMIT;
        end else begin
          lvl_nxt   = lvl_r - IDX_W'(1);
          state_nxt = ST_UNDO;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (found_r) begin
            out_data_nxt.person_index = bfas_pkg::PIDX_W'(emit_k_r);
            out_data_nxt.assigned_job = bfas_pkg::PIDX_W'(best_order_r[emit_k_r]);
            out_data_nxt.total_cost   = best_r;
            out_data_nxt.found        = 1'b1;
            out_data_nxt.last_result  = (CNT_W'(emit_k_r) + CNT_W'(1)) == n;
          end else begin
            out_data_nxt.person_index = '0;
            out_data_nxt.assigned_job = '0;
            out_data_nxt.total_cost   = cost_bound;
            out_data_nxt.found        = 1'b0;
            out_data_nxt.last_result  = 1'b1;
          end
          if (out_data_nxt.last_result) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_k_nxt = emit_k_r + IDX_W'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= q_head.cost_value;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    best_order_r <= best_order_nxt;
    best_r       <= best_nxt;
    ev_idx_r     <= ev_idx_nxt;
    ev_row_r     <= ev_row_nxt;
    acc_r        <= acc_nxt;
    rd_last_r    <= rd_last_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_r       <= '0;
      found_r     <= 1'b0;
      ev_issue_r  <= 1'b0;
      rd_valid_r  <= 1'b0;
      emit_k_r    <= '0;
      out_valid_r <= 1'b0;
      for (int e = 0; e < MAX_SIZE; e++) begin
        cnt_r[e]   <= '0;
        order_r[e] <= IDX_W'(e);
      end
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      found_r     <= found_nxt;
      ev_issue_r  <= ev_issue_nxt;
      rd_valid_r  <= rd_valid_nxt;
      emit_k_r    <= emit_k_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      order_r     <= order_nxt;
    end
  end

endmodule

// ===== rtl/brute_force_assignment_solver.sv =====
// Top level of the brute-force assignment solver: configuration, front end, queue, search.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   in_     | request   | in_valid/in_stall  | in_req_t: cost_value, last_entry
//   out_    | result    | out_valid/out_stall| out_res_t: person, job, total, flags
//   cfg_    | write     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A request is queued and, while fewer than n*n entries are loaded, written into the matrix
// when the idle search engine takes it. A request with last_entry then searches every
// permutation: each is summed from matrix reads, one per row, between level moves.
// Results leave one per cycle while out_stall is low: n, or one if none beats the bound.
// Reset loads problem_size 4 and cost_bound 100 and empties the queue; the matrix keeps data.
// in_stall rises when the two-entry queue is full; out_stall holds the result register.
module brute_force_assignment_solver #(
  parameter int MAX_SIZE = bfas_pkg::MAX_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bfas_pkg::in_req_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bfas_pkg::out_res_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bfas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfas_pkg::BOUND_W-1:0]       cfg_data
);

  localparam int CNT_W  = $clog2(MAX_SIZE + 1);
  localparam int LOAD_W = $clog2(MAX_SIZE * MAX_SIZE + 1);

  logic [bfas_pkg::SIZE_W-1:0]  size_r, size_nxt;
  logic [bfas_pkg::BOUND_W-1:0] bound_r, bound_nxt;
  logic [CNT_W-1:0]             n_act;
  logic [LOAD_W-1:0]            nn;

  logic                         q_push;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_valid;
  bfas_pkg::load_req_t          q_req;
  bfas_pkg::load_req_t          q_head;

  assign cfg_ready = 1'b1;

  always_comb begin
    size_nxt  = size_r;
    bound_nxt = bound_r;
    if (cfg_valid) begin
      unique case (bfas_pkg::cfg_reg_t'(cfg_index))
        bfas_pkg::CFG_PROBLEM_SIZE: size_nxt  = cfg_data[bfas_pkg::SIZE_W-1:0];
        bfas_pkg::CFG_COST_BOUND:   bound_nxt = cfg_data;
        default:                    size_nxt  = size_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= bfas_pkg::SIZE_RESET;
      bound_r <= bfas_pkg::BOUND_RESET;
    end else begin
      size_r  <= size_nxt;
      bound_r <= bound_nxt;
    end
  end

  always_comb begin
    priority if (size_r == '0) begin
      n_act = CNT_W'(1);
    end else if (size_r > bfas_pkg::SIZE_W'(MAX_SIZE)) begin
      n_act = CNT_W'(MAX_SIZE);
    end else begin
      n_act = CNT_W'(size_r);
    end
  end

  assign nn = LOAD_W'(n_act) * LOAD_W'(n_act);

  bfas_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .nn       (nn),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_req    (q_req)
  );

  bfas_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_req   (q_req),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_req   (q_head)
  );

  bfas_back #(
    .MAX_SIZE (MAX_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .n          (n_act),
    .cost_bound (bound_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/bfas_checker.sv =====
// Port-level checks on the solver's result channel, bound to the top level.
module bfas_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input bfas_pkg::out_res_t out_data
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_not_found_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      out_data.last_result && out_data.person_index == '0 && out_data.assigned_job == '0)
    else $error("not-found result is not a lone final result");

  a_mid_run_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |-> out_data.found)
    else $error("non-final result without found");

  a_run_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_result |=>
      out_valid &&
      out_data.person_index == bfas_pkg::PIDX_W'($past(out_data.person_index) + 1'b1) &&
      out_data.total_cost == $past(out_data.total_cost))
    else $error("answer run broke person order or total");

endmodule

bind brute_force_assignment_solver bfas_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== test/tb.sv =====
// Testbench for the brute-force assignment solver: directed table, random loads, result checks.
`timescale 1ns / 100ps

module tb;

  localparam int MAX_N        = bfas_pkg::MAX_SIZE_DEF;
  localparam int SETTLE_WAIT  = 16;
  localparam int LONG_HOLD    = 400;
  localparam int QUIET_LIMIT  = 2000000;
  localparam int BOUND_TOP    = 524287;

  typedef struct packed {
    logic signed [31:0]           new_size;
    logic signed [31:0]           new_bound;
    bfas_pkg::in_req_t            req;
    logic                         typed;
    logic [bfas_pkg::BOUND_W-1:0] total;
    logic                         found;
  } step_t;

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  bfas_pkg::in_req_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  bfas_pkg::out_res_t             out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bfas_pkg::CFG_IDX_W-1:0] cfg_index = bfas_pkg::CFG_PROBLEM_SIZE;
  logic [bfas_pkg::BOUND_W-1:0]   cfg_data  = '0;

  // solver state as seen by the testbench
  logic [bfas_pkg::COST_W-1:0]  cost_mat [64];
  int unsigned                  loaded = 0;
  logic [bfas_pkg::SIZE_W-1:0]  size_reg = bfas_pkg::SIZE_RESET;
  logic [bfas_pkg::BOUND_W-1:0] bound_reg = bfas_pkg::BOUND_RESET;
  logic [7:0][2:0]              order;
  logic [7:0][2:0]              best_order;
  logic [19:0]                  best_sum;
  bit                           improved;
  bfas_pkg::out_res_t           pred_res [8];
  int                           pred_cnt;

  bfas_pkg::out_res_t awaited_answers [$];
  step_t              directed [$];
  int                 items_sent  = 0;
  int                 answers_due = 0;
  int                 errors      = 0;
  int                 idle_in     = 0;
  int                 stall_pct   = 0;
  int                 holds_asked = 0;

  brute_force_assignment_solver uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // store one entry and, on the final one, walk every job order in swap order
  task automatic load_and_solve(input bfas_pkg::in_req_t r);
    int unsigned n, lvl, k;
    int unsigned next_i [8];
    logic [19:0] sum;
    logic [2:0]  t;
    bit walking, ascend;
    n = (size_reg == 0) ? 1 : (size_reg > MAX_N) ? MAX_N : size_reg;
    pred_cnt = 0;
    if (loaded < n * n) begin
      cost_mat[loaded] = r.cost_value;
      loaded++;
    end
    if (r.last_entry) begin
      for (k = 0; k < 8; k++) order[k] = 3'(k);
      best_sum = 20'(bound_reg);
      improved = 0;
      lvl = 0;
      next_i[0] = 0;
      walking = 1;
      while (walking) begin
        ascend = 1;
        if (lvl + 1 >= n) begin
          sum = 0;
          for (k = 0; k < n; k++) sum += 20'(cost_mat[k * n + order[k]]);
          if (sum < best_sum) begin
            best_sum = sum;
            improved = 1;
            best_order = order;
          end
        end else if (next_i[lvl] < n) begin
          t = order[lvl];
          order[lvl] = order[next_i[lvl]];
          order[next_i[lvl]] = t;
          lvl++;
          next_i[lvl] = lvl;
          ascend = 0;
        end
        if (ascend) begin
          if (lvl == 0) begin
            walking = 0;
          end else begin
            lvl--;
            t = order[lvl];
            order[lvl] = order[next_i[lvl]];
            order[next_i[lvl]] = t;
            next_i[lvl]++;
          end
        end
      end
      loaded = 0;
      if (!improved) begin
        pred_res[0] = {3'd0, 3'd0, bound_reg, 1'b0, 1'b1};
        pred_cnt = 1;
      end else begin
        for (k = 0; k < n; k++) begin
          pred_res[k].person_index = bfas_pkg::PIDX_W'(k);
          pred_res[k].assigned_job = best_order[k];
          pred_res[k].total_cost   = best_sum[bfas_pkg::BOUND_W-1:0];
          pred_res[k].found        = 1'b1;
          pred_res[k].last_result  = (k + 1 == n);
        end
        pred_cnt = n;
      end
    end
  endtask

  task automatic send_entry(input bfas_pkg::in_req_t r, input bit typed, input int total,
                            input bit fnd);
    bfas_pkg::out_res_t ans;
    int k;
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    items_sent++;
    load_and_solve(r);
    if (typed) begin
      ans = {3'd0, 3'd0, total[bfas_pkg::BOUND_W-1:0], fnd, 1'b1};
      awaited_answers.push_back(ans);
      answers_due++;
    end else begin
      for (k = 0; k < pred_cnt; k++) awaited_answers.push_back(pred_res[k]);
      answers_due += pred_cnt;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input bfas_pkg::cfg_reg_t idx,
                           input logic [bfas_pkg::BOUND_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bfas_pkg::CFG_PROBLEM_SIZE) size_reg = d[bfas_pkg::SIZE_W-1:0];
    else bound_reg = d;
  endtask

  // negative arguments leave a register as it is
  task automatic configure(input int sz, input int bd);
    logic [bfas_pkg::BOUND_W-1:0] d;
    settle();
    if (sz >= 0) begin
      d = bfas_pkg::BOUND_W'($urandom);
      d[bfas_pkg::SIZE_W-1:0] = bfas_pkg::SIZE_W'(sz);
      write_reg(bfas_pkg::CFG_PROBLEM_SIZE, d);
    end
    if (bd >= 0) write_reg(bfas_pkg::CFG_COST_BOUND, bfas_pkg::BOUND_W'(bd));
    cfg_valid <= 1'b0;
  endtask

  task automatic add_step(input int sz, input int bd, input int cost, input bit last,
                          input bit typed, input int total, input bit fnd);
    step_t s;
    s.new_size  = sz;
    s.new_bound = bd;
    s.req.cost_value = bfas_pkg::COST_W'(cost);
    s.req.last_entry = last;
    s.typed = typed;
    s.total = bfas_pkg::BOUND_W'(total);
    s.found = fnd;
    directed.push_back(s);
  endtask

  task automatic random_problem();
    int sz, n, cmax, count, k;
    bfas_pkg::in_req_t r;
    cmax = $urandom_range(1) ? 65535 : $urandom_range(1, 15);
    if ($urandom_range(1)) begin
      sz = ($urandom_range(9) == 0) ? 6 : $urandom_range(0, 5);
      n = (sz == 0) ? 1 : sz;
      case ($urandom_range(3))
        0:       configure(sz, BOUND_TOP);
        1:       configure(sz, $urandom_range(0, BOUND_TOP));
        default: configure(sz, $urandom_range(0, n * cmax));
      endcase
    end
    n = (size_reg == 0) ? 1 : (size_reg > MAX_N) ? MAX_N : size_reg;
    count = ($urandom_range(9) < 7) ? n * n : $urandom_range(1, n * n + 3);
    for (k = 0; k < count; k++) begin
      r.cost_value = bfas_pkg::COST_W'($urandom_range(0, cmax));
      r.last_entry = (k == count - 1);
      send_entry(r, 0, 0, 0);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : receiver
    bfas_pkg::out_res_t want;
    int hold_left;
    int holds_given;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_answers.size() == 0) begin
        errors++;
        $error("result for person %0d with none awaited", out_data.person_index);
      end else begin
        want = awaited_answers.pop_front();
        check_field("person_index", want.person_index, out_data.person_index);
        check_field("assigned_job", want.assigned_job, out_data.assigned_job);
        check_field("total_cost", want.total_cost, out_data.total_cost);
        check_field("found", want.found, out_data.found);
        check_field("last_result", want.last_result, out_data.last_result);
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_given != holds_asked) begin
      // hold the result channel for a long stretch
      holds_given++;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("brute_force_assignment_solver test failed");
    $finish;
  end

  initial begin : stimulus
    int sender_idle [4];
    int result_stall [4];
    int k, ph, first_items, first_due;
    step_t s;
    bfas_pkg::in_req_t r;
    sender_idle  = '{0, 81, 0, 22};
    result_stall = '{0, 0, 81, 22};

    // reset settings, diagonal of zeros among maximum costs
    for (k = 0; k < 16; k++) add_step(-1, -1, (k % 5 == 0) ? 0 : 65535, k == 15, 0, 0, 0);
    add_step(1, BOUND_TOP, 65535, 1, 1, 65535, 1);
    add_step(-1, 0, 0, 1, 1, 0, 0);
    add_step(0, 100, 99, 1, 1, 99, 1);
    add_step(-1, -1, 100, 1, 1, 100, 0);
    // surplus requests after a full load
    add_step(-1, BOUND_TOP, 1234, 0, 0, 0, 0);
    add_step(-1, -1, 65535, 0, 0, 0, 0);
    add_step(-1, -1, 0, 1, 1, 1234, 1);
    // short load over earlier contents
    add_step(2, BOUND_TOP, 7, 1, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[k]) begin
      s = directed[k];
      if (s.new_size >= 0 || s.new_bound >= 0) configure(s.new_size, s.new_bound);
      send_entry(s.req, s.typed, s.total, s.found);
    end

    for (ph = 0; ph < 4; ph++) begin
      settle();
      idle_in   = sender_idle[ph];
      stall_pct = result_stall[ph];
      first_items = items_sent;
      first_due   = answers_due;
      if (ph == 0) begin
        // fill the whole matrix at the largest size
        configure(MAX_N, BOUND_TOP);
        for (k = 0; k < 64; k++) begin
          r.cost_value = bfas_pkg::COST_W'($urandom);
          r.last_entry = (k == 63);
          send_entry(r, 0, 0, 0);
        end
        configure(15, $urandom_range(0, BOUND_TOP));
        r.cost_value = bfas_pkg::COST_W'($urandom);
        r.last_entry = 1'b1;
        send_entry(r, 0, 0, 0);
        // keep offering requests while results are held back
        configure(2, BOUND_TOP);
        holds_asked++;
        for (k = 0; k < 8; k++) begin
          r.cost_value = bfas_pkg::COST_W'($urandom);
          r.last_entry = (k % 4 == 3);
          send_entry(r, 0, 0, 0);
        end
      end
      while (items_sent - first_items < 4 || answers_due - first_due < 2) random_problem();
    end

    settle();
    if (errors == 0)
      $display("brute_force_assignment_solver test passed");
    else
      $display("brute_force_assignment_solver test failed");
    $finish;
  end

endmodule
